// ===== rtl/mabe_pkg.sv =====
// Package for the misc ALU and branch execute unit: field widths, opcodes,
// machine-cycle codes and the decoded control struct. No dependencies.
package mabe_pkg;

   localparam int unsigned ByteW  = 8;
   localparam int unsigned AddrW  = 16;
   localparam int unsigned CycW   = 3;

   // opcodes of the group
   localparam logic [ByteW-1:0] OP_JR     = 8'h18;
   localparam logic [ByteW-1:0] OP_JR_NZ  = 8'h20;
   localparam logic [ByteW-1:0] OP_JR_Z   = 8'h28;
   localparam logic [ByteW-1:0] OP_JR_NC  = 8'h30;
   localparam logic [ByteW-1:0] OP_JR_C   = 8'h38;
   localparam logic [ByteW-1:0] OP_DAA    = 8'h27;
   localparam logic [ByteW-1:0] OP_CPL    = 8'h2F;
   localparam logic [ByteW-1:0] OP_SCF    = 8'h37;
   localparam logic [ByteW-1:0] OP_CCF    = 8'h3F;
   localparam logic [ByteW-1:0] OP_JP_NZ  = 8'hC2;
   localparam logic [ByteW-1:0] OP_JP     = 8'hC3;
   localparam logic [ByteW-1:0] OP_JP_Z   = 8'hCA;
   localparam logic [ByteW-1:0] OP_JP_NC  = 8'hD2;
   localparam logic [ByteW-1:0] OP_JP_C   = 8'hDA;
   localparam logic [ByteW-1:0] OP_JP_HL  = 8'hE9;
   localparam logic [ByteW-1:0] OP_DI     = 8'hF3;
   localparam logic [ByteW-1:0] OP_EI     = 8'hFB;

   // machine-cycle counts
   localparam logic [CycW-1:0] CYC_NONE = 3'd0;
   localparam logic [CycW-1:0] CYC_1    = 3'd1;
   localparam logic [CycW-1:0] CYC_2    = 3'd2;
   localparam logic [CycW-1:0] CYC_3    = 3'd3;
   localparam logic [CycW-1:0] CYC_4    = 3'd4;

   // decimal adjust constants
   localparam logic [ByteW-1:0] DAA_HI_LIMIT = 8'h99;
   localparam logic [3:0]       DAA_LO_LIMIT = 4'd9;
   localparam logic [3:0]       DAA_FIX      = 4'h6;

   typedef struct packed {
      logic daa;
      logic cpl;
      logic ccf;
      logic scf;
      logic jp_abs;
      logic jp_cond;
      logic jp_hl;
      logic jr;
      logic jr_cond;
      logic di;
      logic ei;
   } ctrl_type;

endpackage

// ===== rtl/mabe_if.sv =====
// Request and response channel interfaces of the misc ALU and branch unit.
// Depends on mabe_pkg for field widths.
interface mabe_req_if import mabe_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ByteW-1:0] opcode;
   logic [ByteW-1:0] acc_in;
   logic             zero_in;
   logic             sub_in;
   logic             half_in;
   logic             carry_in;
   logic [AddrW-1:0] pc_in;
   logic [AddrW-1:0] hl_in;
   logic [ByteW-1:0] imm_low;
   logic [ByteW-1:0] imm_high;
   logic             ime_in;

   modport source (output valid, opcode, acc_in, zero_in, sub_in, half_in, carry_in,
                   pc_in, hl_in, imm_low, imm_high, ime_in, input ready);
   modport sink   (input valid, opcode, acc_in, zero_in, sub_in, half_in, carry_in,
                   pc_in, hl_in, imm_low, imm_high, ime_in, output ready);
endinterface

interface mabe_rsp_if import mabe_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ByteW-1:0] acc_out;
   logic             zero_out;
   logic             sub_out;
   logic             half_out;
   logic             carry_out;
   logic [AddrW-1:0] pc_out;
   logic             ime_out;
   logic [CycW-1:0]  machine_cycles;
   logic             handled;

   modport source (output valid, acc_out, zero_out, sub_out, half_out, carry_out,
                   pc_out, ime_out, machine_cycles, handled, input ready);
   modport sink   (input valid, acc_out, zero_out, sub_out, half_out, carry_out,
                   pc_out, ime_out, machine_cycles, handled, output ready);
endinterface

// ===== rtl/mabe_decode.sv =====
// Opcode decoder: turns the opcode byte into the control struct.
// Depends on mabe_pkg.
module mabe_decode import mabe_pkg::*; (
   input  logic [ByteW-1:0] opcode,
   output ctrl_type         ctrl
);

   always_comb begin
      ctrl = '0;
      unique case (opcode)
         OP_DAA:   ctrl.daa = 1'b1;
         OP_CPL:   ctrl.cpl = 1'b1;
         OP_CCF:   ctrl.ccf = 1'b1;
         OP_SCF:   ctrl.scf = 1'b1;
         OP_JP:    ctrl.jp_abs = 1'b1;
         OP_JP_NZ, OP_JP_Z, OP_JP_NC, OP_JP_C: ctrl.jp_cond = 1'b1;
         OP_JP_HL: ctrl.jp_hl = 1'b1;
         OP_JR:    ctrl.jr = 1'b1;
         OP_JR_NZ, OP_JR_Z, OP_JR_NC, OP_JR_C: ctrl.jr_cond = 1'b1;
         OP_DI:    ctrl.di = 1'b1;
         OP_EI:    ctrl.ei = 1'b1;
         default:  ctrl = '0;
      endcase
   end

endmodule

// ===== rtl/mabe_alu.sv =====
// Accumulator, flag and interrupt-enable logic of the execute unit.
// Depends on mabe_pkg (ctrl_type, decimal adjust constants).
module mabe_alu import mabe_pkg::*; (
   input  ctrl_type         ctrl,
   input  logic [ByteW-1:0] acc_in,
   input  logic             zero_in,
   input  logic             sub_in,
   input  logic             half_in,
   input  logic             carry_in,
   input  logic             ime_in,
   output logic [ByteW-1:0] acc_out,
   output logic             zero_out,
   output logic             sub_out,
   output logic             half_out,
   output logic             carry_out,
   output logic             ime_out
);

   logic             adj_hi;
   logic             adj_lo;
   logic [ByteW-1:0] corr;
   logic [ByteW-1:0] daa_res;

   // adding 0x60 leaves the low nibble alone, so both tests look at acc_in
   assign adj_hi  = sub_in ? carry_in : (carry_in || (acc_in > DAA_HI_LIMIT));
   assign adj_lo  = sub_in ? half_in  : (half_in  || (acc_in[3:0] > DAA_LO_LIMIT));
   assign corr    = {(adj_hi ? DAA_FIX : 4'h0), (adj_lo ? DAA_FIX : 4'h0)};
   assign daa_res = sub_in ? (acc_in - corr) : (acc_in + corr);

   always_comb begin
      acc_out   = acc_in;
      zero_out  = zero_in;
      sub_out   = sub_in;
      half_out  = half_in;
      carry_out = carry_in;
      ime_out   = ime_in;
      if (ctrl.daa) begin
         acc_out   = daa_res;
         zero_out  = (daa_res == '0);
         half_out  = 1'b0;
         carry_out = adj_hi;
      end
      if (ctrl.cpl) begin
         acc_out  = ~acc_in;
         sub_out  = 1'b1;
         half_out = 1'b1;
      end
      if (ctrl.ccf || ctrl.scf) begin
         carry_out = ctrl.scf | ~carry_in;
         sub_out   = 1'b0;
         half_out  = 1'b0;
      end
      if (ctrl.di) ime_out = 1'b0;
      if (ctrl.ei) ime_out = 1'b1;
   end

endmodule

// ===== rtl/mabe_branch.sv =====
// Next-PC, machine-cycle count and handled flag of the execute unit.
// Depends on mabe_pkg (ctrl_type, cycle codes).
module mabe_branch import mabe_pkg::*; (
   input  ctrl_type         ctrl,
   input  logic [ByteW-1:0] opcode,
   input  logic             zero_in,
   input  logic             carry_in,
   input  logic [AddrW-1:0] pc_in,
   input  logic [AddrW-1:0] hl_in,
   input  logic [ByteW-1:0] imm_low,
   input  logic [ByteW-1:0] imm_high,
   output logic [AddrW-1:0] pc_out,
   output logic [CycW-1:0]  machine_cycles,
   output logic             handled
);

   logic             cond;
   logic [AddrW-1:0] pc_plus1;
   logic [AddrW-1:0] pc_plus2;
   logic [AddrW-1:0] pc_plus3;
   logic [AddrW-1:0] rel_target;
   logic [AddrW-1:0] abs_target;

   // opcode bit 4 picks carry over zero, bit 3 the polarity tested
   assign cond       = (opcode[4] ? carry_in : zero_in) == opcode[3];
   assign pc_plus1   = pc_in + AddrW'(1);
   assign pc_plus2   = pc_in + AddrW'(2);
   assign pc_plus3   = pc_in + AddrW'(3);
   assign rel_target = pc_plus2 + {{(AddrW-ByteW){imm_low[ByteW-1]}}, imm_low};
   assign abs_target = {imm_high, imm_low};
   assign handled    = |ctrl;

   always_comb begin
      pc_out         = pc_in;
      machine_cycles = CYC_NONE;
      if (ctrl.daa || ctrl.cpl || ctrl.ccf || ctrl.scf || ctrl.di || ctrl.ei) begin
         pc_out         = pc_plus1;
         machine_cycles = CYC_1;
      end
      if (ctrl.jp_abs || (ctrl.jp_cond && cond)) begin
         pc_out         = abs_target;
         machine_cycles = CYC_4;
      end
      if (ctrl.jp_cond && !cond) begin
         pc_out         = pc_plus3;
         machine_cycles = CYC_3;
      end
      if (ctrl.jp_hl) begin
         pc_out         = hl_in;
         machine_cycles = CYC_1;
      end
      if (ctrl.jr || (ctrl.jr_cond && cond)) begin
         pc_out         = rel_target;
         machine_cycles = CYC_3;
      end
      if (ctrl.jr_cond && !cond) begin
         pc_out         = pc_plus2;
         machine_cycles = CYC_2;
      end
   end

endmodule

// ===== rtl/misc_alu_and_branch_execute_unit.sv =====
// Top level of the misc ALU and branch execute unit: input register,
// decode/ALU/branch logic, response register. Depends on mabe_pkg, mabe_if,
// mabe_decode, mabe_alu and mabe_branch.
// A request goes from the input register on to the response register and is held
// there while the response side stalls. Throughput: 1 request per cycle while the
// response side does not stall; each register holds one request and advances
// when the response register is empty or the response side takes its request.
// Reset: synchronous, active high; clears both valid bits, payloads keep junk.
module misc_alu_and_branch_execute_unit import mabe_pkg::*; (
   input logic          clock,
   input logic          reset,
   mabe_req_if.sink     req_bus,
   mabe_rsp_if.source   rsp_bus
);

   // ---------------- input register ----------------
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_ready;
   logic [ByteW-1:0] op_ff;
   logic [ByteW-1:0] acc_ff;
   logic             zero_ff, sub_ff, half_ff, carry_ff, ime_ff;
   logic [AddrW-1:0] pc_ff;
   logic [AddrW-1:0] hl_ff;
   logic [ByteW-1:0] imm_low_ff, imm_high_ff;

   // ---------------- response register ----------------
   logic             s2_valid_ff, s2_valid_in;
   logic             s2_ready;
   logic             s2_load;

   // ---------------- execute results ----------------
   ctrl_type         ctrl;
   logic [ByteW-1:0] acc_res;
   logic             zero_res, sub_res, half_res, carry_res, ime_res;
   logic [AddrW-1:0] pc_res;
   logic [CycW-1:0]  cyc_res;
   logic             handled_res;

   // Each stage takes a new request when empty or when it empties this cycle.
   assign s2_ready      = !s2_valid_ff || rsp_bus.ready;
   assign s1_ready      = !s1_valid_ff || s2_ready;
   assign req_bus.ready = s1_ready;
   assign s2_load       = s1_valid_ff && s2_ready;

   assign s1_valid_in = req_bus.valid ? 1'b1 : (s1_valid_ff && !s2_ready);
   assign s2_valid_in = s2_load ? 1'b1 : (s2_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Capture the request fields; hold them while the response side stalls.
   always_ff @(posedge clock) begin
      if (req_bus.valid && s1_ready) begin
         op_ff       <= req_bus.opcode;
         acc_ff      <= req_bus.acc_in;
         zero_ff     <= req_bus.zero_in;
         sub_ff      <= req_bus.sub_in;
         half_ff     <= req_bus.half_in;
         carry_ff    <= req_bus.carry_in;
         pc_ff       <= req_bus.pc_in;
         hl_ff       <= req_bus.hl_in;
         imm_low_ff  <= req_bus.imm_low;
         imm_high_ff <= req_bus.imm_high;
         ime_ff      <= req_bus.ime_in;
      end
   end

   mabe_decode u_decode (
      .opcode (op_ff),
      .ctrl   (ctrl)
   );

   mabe_alu u_alu (
      .ctrl      (ctrl),
      .acc_in    (acc_ff),
      .zero_in   (zero_ff),
      .sub_in    (sub_ff),
      .half_in   (half_ff),
      .carry_in  (carry_ff),
      .ime_in    (ime_ff),
      .acc_out   (acc_res),
      .zero_out  (zero_res),
      .sub_out   (sub_res),
      .half_out  (half_res),
      .carry_out (carry_res),
      .ime_out   (ime_res)
   );

   mabe_branch u_branch (
      .ctrl           (ctrl),
      .opcode         (op_ff),
      .zero_in        (zero_ff),
      .carry_in       (carry_ff),
      .pc_in          (pc_ff),
      .hl_in          (hl_ff),
      .imm_low        (imm_low_ff),
      .imm_high       (imm_high_ff),
      .pc_out         (pc_res),
      .machine_cycles (cyc_res),
      .handled        (handled_res)
   );

   // Load the response register straight from the execute logic.
   always_ff @(posedge clock) begin
      if (s2_load) begin
         rsp_bus.acc_out        <= acc_res;
         rsp_bus.zero_out       <= zero_res;
         rsp_bus.sub_out        <= sub_res;
         rsp_bus.half_out       <= half_res;
         rsp_bus.carry_out      <= carry_res;
         rsp_bus.pc_out         <= pc_res;
         rsp_bus.ime_out        <= ime_res;
         rsp_bus.machine_cycles <= cyc_res;
         rsp_bus.handled        <= handled_res;
      end
   end

   assign rsp_bus.valid = s2_valid_ff;

   // ---------------- assertions ----------------
   // At most one control bit is set by the decoder.
   a_ctrl_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(ctrl))
      else $error("decoder raised more than one instruction class");

   // Handled instructions take cycles, others report none.
   a_cyc_handled: assert property (@(posedge clock) disable iff (reset)
      s2_load |-> (handled_res == (cyc_res != CYC_NONE)))
      else $error("machine cycle count disagrees with handled flag");

   // An unknown opcode passes PC and accumulator through.
   a_pass_through: assert property (@(posedge clock) disable iff (reset)
      (s2_load && !handled_res) |-> (pc_res == pc_ff && acc_res == acc_ff))
      else $error("unhandled opcode changed PC or accumulator");

   // An accepted request occupies the input register next cycle.
   a_accept_fill: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> s1_valid_ff)
      else $error("accepted request was lost");

   // A stalled response keeps the input register from draining.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_valid_ff && !rsp_bus.ready) |=> s1_valid_ff)
      else $error("input register drained during response stall");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for misc_alu_and_branch_execute_unit: a directed table, then
// random requests, each checked against an in-bench model of the instruction group.
// Depends on mabe_pkg, mabe_if and the unit's RTL.
module testbench import mabe_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   // Opcodes outside the group, used to exercise pass-through.
   localparam logic [ByteW-1:0] OP_OUTSIDE_LO = 8'h00;
   localparam logic [ByteW-1:0] OP_OUTSIDE_HI = 8'hFF;
   // Upper-digit correction of the decimal adjust.
   localparam logic [ByteW-1:0] DAA_HI_FIX = 8'h60;

   localparam int RANDOM_COUNT = 800;
   localparam int MAX_GAP      = 10;
   localparam int HOLD_AT      = 150;   // responses seen before the long hold-off
   localparam int HOLD_CYCLES  = 60;
   localparam int DRAIN_CYCLES = 10;    // pipeline is two deep, leave some margin
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [ByteW-1:0] opcode;
      logic [ByteW-1:0] acc;
      logic             zero;
      logic             sub;
      logic             half;
      logic             carry;
      logic [AddrW-1:0] pc;
      logic [AddrW-1:0] hl;
      logic [ByteW-1:0] imm_low;
      logic [ByteW-1:0] imm_high;
      logic             ime;
   } instr_t;

   typedef struct packed {
      logic [ByteW-1:0] acc;
      logic             zero;
      logic             sub;
      logic             half;
      logic             carry;
      logic [AddrW-1:0] pc;
      logic             ime;
      logic [CycW-1:0]  cycles;
      logic             handled;
   } outcome_t;

   typedef struct packed {
      instr_t   ins;
      logic     typed_in;   // expected outcome written into the table
      outcome_t want;
   } directed_row_t;

   logic clock;
   logic reset;

   mabe_req_if req_bus ();
   mabe_rsp_if rsp_bus ();

   misc_alu_and_branch_execute_unit DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Outcomes still owed by the unit, oldest first.
   outcome_t      pending_outcomes[$];
   directed_row_t directed_rows[$];

   int error_count     = 0;
   int responses_seen  = 0;
   int group_requests  = 0;
   int outside_requests = 0;
   int directed_sent   = 0;
   int random_sent     = 0;
   bit hold_done       = 1'b0;

   logic [ByteW-1:0] group_ops [17] = '{
      OP_JR, OP_JR_NZ, OP_JR_Z, OP_JR_NC, OP_JR_C, OP_DAA, OP_CPL, OP_SCF, OP_CCF,
      OP_JP_NZ, OP_JP, OP_JP_Z, OP_JP_NC, OP_JP_C, OP_JP_HL, OP_DI, OP_EI
   };

   // Compute what the unit must return for one instruction.
   function automatic outcome_t execute_instr(input instr_t ins);
      outcome_t         r;
      logic             taken;
      logic [ByteW-1:0] a;
      logic [AddrW-1:0] abs_target;
      logic [AddrW-1:0] rel_target;
      // Default: pass everything through with no cycles, marked handled.
      r.acc     = ins.acc;
      r.zero    = ins.zero;
      r.sub     = ins.sub;
      r.half    = ins.half;
      r.carry   = ins.carry;
      r.pc      = ins.pc;
      r.ime     = ins.ime;
      r.cycles  = CYC_NONE;
      r.handled = 1'b1;
      abs_target = {ins.imm_high, ins.imm_low};
      // Relative offset is signed; the sum wraps at 16 bits.
      rel_target = ins.pc + AddrW'(2) + {{(AddrW-ByteW){ins.imm_low[ByteW-1]}}, ins.imm_low};
      case (ins.opcode)
         OP_JR_NZ, OP_JP_NZ: taken = !ins.zero;
         OP_JR_Z,  OP_JP_Z:  taken = ins.zero;
         OP_JR_NC, OP_JP_NC: taken = !ins.carry;
         OP_JR_C,  OP_JP_C:  taken = ins.carry;
         default:            taken = 1'b0;
      endcase
      case (ins.opcode)
         OP_DAA: begin
            a = ins.acc;
            if (!ins.sub) begin
               if (ins.carry || a > DAA_HI_LIMIT) begin
                  a = a + DAA_HI_FIX;
                  r.carry = 1'b1;
               end
               if (ins.half || a[3:0] > DAA_LO_LIMIT) a = a + {4'h0, DAA_FIX};
            end else begin
               // Subtract mode keeps the carry as it is.
               if (ins.carry) a = a - DAA_HI_FIX;
               if (ins.half) a = a - {4'h0, DAA_FIX};
            end
            r.acc    = a;
            r.zero   = (a == '0);
            r.half   = 1'b0;
            r.pc     = ins.pc + AddrW'(1);
            r.cycles = CYC_1;
         end
         OP_CPL: begin
            r.acc    = ~ins.acc;
            r.sub    = 1'b1;
            r.half   = 1'b1;
            r.pc     = ins.pc + AddrW'(1);
            r.cycles = CYC_1;
         end
         OP_CCF, OP_SCF: begin
            r.carry  = (ins.opcode == OP_SCF) ? 1'b1 : !ins.carry;
            r.sub    = 1'b0;
            r.half   = 1'b0;
            r.pc     = ins.pc + AddrW'(1);
            r.cycles = CYC_1;
         end
         OP_JP: begin
            r.pc     = abs_target;
            r.cycles = CYC_4;
         end
         OP_JP_NZ, OP_JP_Z, OP_JP_NC, OP_JP_C: begin
            r.pc     = taken ? abs_target : ins.pc + AddrW'(3);
            r.cycles = taken ? CYC_4 : CYC_3;
         end
         OP_JP_HL: begin
            r.pc     = ins.hl;
            r.cycles = CYC_1;
         end
         OP_JR: begin
            r.pc     = rel_target;
            r.cycles = CYC_3;
         end
         OP_JR_NZ, OP_JR_Z, OP_JR_NC, OP_JR_C: begin
            r.pc     = taken ? rel_target : ins.pc + AddrW'(2);
            r.cycles = taken ? CYC_3 : CYC_2;
         end
         OP_DI, OP_EI: begin
            r.ime    = (ins.opcode == OP_EI);
            r.pc     = ins.pc + AddrW'(1);
            r.cycles = CYC_1;
         end
         default: r.handled = 1'b0;
      endcase
      return r;
   endfunction

   function automatic instr_t pack_instr(
      input logic [ByteW-1:0] opcode, input logic [ByteW-1:0] acc,
      input logic z, input logic n, input logic h, input logic c,
      input logic [AddrW-1:0] pc, input logic [AddrW-1:0] hl,
      input logic [ByteW-1:0] lo, input logic [ByteW-1:0] hi, input logic ime);
      instr_t ins;
      ins.opcode   = opcode;
      ins.acc      = acc;
      ins.zero     = z;
      ins.sub      = n;
      ins.half     = h;
      ins.carry    = c;
      ins.pc       = pc;
      ins.hl       = hl;
      ins.imm_low  = lo;
      ins.imm_high = hi;
      ins.ime      = ime;
      return ins;
   endfunction

   function automatic outcome_t pack_outcome(
      input logic [ByteW-1:0] acc, input logic z, input logic n, input logic h,
      input logic c, input logic [AddrW-1:0] pc, input logic ime,
      input logic [CycW-1:0] cycles, input logic handled);
      outcome_t r;
      r.acc     = acc;
      r.zero    = z;
      r.sub     = n;
      r.half    = h;
      r.carry   = c;
      r.pc      = pc;
      r.ime     = ime;
      r.cycles  = cycles;
      r.handled = handled;
      return r;
   endfunction

   task automatic add_row(input instr_t ins, input logic typed_in, input outcome_t want);
      directed_row_t row;
      row.ins      = ins;
      row.typed_in = typed_in;
      row.want     = want;
      directed_rows.push_back(row);
   endtask

   // Offer one request after a gap of idle cycles; return once it is accepted.
   task automatic send_request(input instr_t ins, input outcome_t want, input int gap);
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.opcode   = ins.opcode;
      req_bus.acc_in   = ins.acc;
      req_bus.zero_in  = ins.zero;
      req_bus.sub_in   = ins.sub;
      req_bus.half_in  = ins.half;
      req_bus.carry_in = ins.carry;
      req_bus.pc_in    = ins.pc;
      req_bus.hl_in    = ins.hl;
      req_bus.imm_low  = ins.imm_low;
      req_bus.imm_high = ins.imm_high;
      req_bus.ime_in   = ins.ime;
      req_bus.valid    = 1'b1;
      // Hold the request until the unit takes it.
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_outcomes.push_back(want);
      if (want.handled) group_requests++;
      else outside_requests++;
   endtask

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: the slowest correct run is far below this.
   initial begin
      #2_000_000;
      $display("** misc_alu_and_branch_execute_unit: FAILED **");
      $finish;
   end

   // Stimulus: reset, directed table, random requests, then drain and report.
   initial begin : stimulus
      instr_t   ins;
      outcome_t want;
      int       gap;
      bit       burst;
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.opcode   = '0;
      req_bus.acc_in   = '0;
      req_bus.zero_in  = 1'b0;
      req_bus.sub_in   = 1'b0;
      req_bus.half_in  = 1'b0;
      req_bus.carry_in = 1'b0;
      req_bus.pc_in    = '0;
      req_bus.hl_in    = '0;
      req_bus.imm_low  = '0;
      req_bus.imm_high = '0;
      req_bus.ime_in   = 1'b0;

      // Outside the group: everything passes through, no cycles.
      add_row(pack_instr(OP_OUTSIDE_LO, 8'h00, 0, 0, 0, 0, 16'h0000, 16'h0000, 8'h00, 8'h00, 0),
              1, pack_outcome(8'h00, 0, 0, 0, 0, 16'h0000, 0, CYC_NONE, 0));
      add_row(pack_instr(OP_OUTSIDE_HI, 8'hFF, 1, 1, 1, 1, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 1),
              1, pack_outcome(8'hFF, 1, 1, 1, 1, 16'hFFFF, 1, CYC_NONE, 0));
      // Decimal adjust: both corrections wrapping to zero, half-carry only,
      // subtract mode with and without borrows, plain zero.
      add_row(pack_instr(OP_DAA, 8'h9A, 0, 0, 0, 0, 16'h0100, 16'h0000, 8'h00, 8'h00, 0), 0, '0);
      add_row(pack_instr(OP_DAA, 8'h00, 0, 0, 1, 0, 16'h0200, 16'h0000, 8'h00, 8'h00, 0), 0, '0);
      add_row(pack_instr(OP_DAA, 8'h00, 0, 1, 1, 1, 16'h0300, 16'h0000, 8'h00, 8'h00, 0), 0, '0);
      add_row(pack_instr(OP_DAA, 8'h45, 1, 1, 0, 0, 16'h0400, 16'h0000, 8'h00, 8'h00, 0), 0, '0);
      add_row(pack_instr(OP_DAA, 8'h00, 0, 0, 0, 0, 16'hFFFF, 16'h0000, 8'h00, 8'h00, 0), 0, '0);
      // Complement A at the top of memory: PC wraps to zero.
      add_row(pack_instr(OP_CPL, 8'h00, 0, 0, 0, 1, 16'hFFFF, 16'h0000, 8'h00, 8'h00, 0),
              1, pack_outcome(8'hFF, 0, 1, 1, 1, 16'h0000, 0, CYC_1, 1));
      add_row(pack_instr(OP_CCF, 8'h12, 0, 1, 1, 1, 16'h0500, 16'h0000, 8'h00, 8'h00, 0), 0, '0);
      add_row(pack_instr(OP_CCF, 8'h12, 1, 1, 1, 0, 16'h0501, 16'h0000, 8'h00, 8'h00, 1), 0, '0);
      add_row(pack_instr(OP_SCF, 8'h34, 0, 1, 1, 0, 16'h0600, 16'h0000, 8'h00, 8'h00, 0), 0, '0);
      // Absolute jump: target is the two immediate bytes.
      add_row(pack_instr(OP_JP, 8'h5A, 1, 0, 1, 0, 16'hFFFF, 16'h0000, 8'h34, 8'h12, 1),
              1, pack_outcome(8'h5A, 1, 0, 1, 0, 16'h1234, 1, CYC_4, 1));
      add_row(pack_instr(OP_JP_NZ, 8'h00, 0, 0, 0, 0, 16'h0700, 16'h0000, 8'hCD, 8'hAB, 0),
              0, '0);
      // Not taken at the top of memory: PC+3 wraps.
      add_row(pack_instr(OP_JP_Z, 8'h00, 0, 0, 0, 0, 16'hFFFE, 16'h0000, 8'hCD, 8'hAB, 0),
              0, '0);
      add_row(pack_instr(OP_JP_NC, 8'h00, 0, 0, 0, 1, 16'h0800, 16'h0000, 8'hFF, 8'hFF, 0),
              0, '0);
      add_row(pack_instr(OP_JP_C, 8'h00, 0, 0, 0, 1, 16'h0900, 16'h0000, 8'h00, 8'h00, 0),
              0, '0);
      add_row(pack_instr(OP_JP_HL, 8'h00, 0, 0, 0, 0, 16'h0A00, 16'hFFFF, 8'h00, 8'h00, 0),
              0, '0);
      // Relative jumps: largest forward offset across the wrap, largest backward
      // offset from zero, a jump to itself, one outcome of each condition.
      add_row(pack_instr(OP_JR, 8'h00, 0, 0, 0, 0, 16'hFFFF, 16'h0000, 8'h7F, 8'h00, 0), 0, '0);
      add_row(pack_instr(OP_JR, 8'h00, 0, 0, 0, 0, 16'h0000, 16'h0000, 8'h80, 8'h00, 0), 0, '0);
      add_row(pack_instr(OP_JR_NZ, 8'h00, 1, 0, 0, 0, 16'hFFFF, 16'h0000, 8'h10, 8'h00, 0),
              0, '0);
      add_row(pack_instr(OP_JR_Z, 8'h00, 1, 0, 0, 0, 16'h0B00, 16'h0000, 8'hFE, 8'h00, 0),
              0, '0);
      add_row(pack_instr(OP_JR_NC, 8'h00, 0, 0, 0, 0, 16'h0C00, 16'h0000, 8'h81, 8'h00, 0),
              0, '0);
      add_row(pack_instr(OP_JR_C, 8'h00, 0, 0, 0, 0, 16'h0D00, 16'h0000, 8'h05, 8'h00, 0),
              0, '0);
      add_row(pack_instr(OP_DI, 8'h00, 0, 0, 0, 0, 16'h1000, 16'h0000, 8'h00, 8'h00, 1),
              1, pack_outcome(8'h00, 0, 0, 0, 0, 16'h1001, 0, CYC_1, 1));
      add_row(pack_instr(OP_EI, 8'h00, 0, 0, 0, 0, 16'hFFFF, 16'h0000, 8'h00, 8'h00, 0),
              1, pack_outcome(8'h00, 0, 0, 0, 0, 16'h0000, 1, CYC_1, 1));

      // Release reset at a falling edge.
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         want = directed_rows[i].typed_in ? directed_rows[i].want
                                          : execute_instr(directed_rows[i].ins);
         send_request(directed_rows[i].ins, want, $urandom_range(0, MAX_GAP));
         directed_sent++;
      end

      // Random part: mostly group opcodes, the rest any byte at all.
      burst = 1'b0;
      for (int k = 0; k < RANDOM_COUNT; k++) begin
         // Toggle now and then into stretches of back-to-back requests.
         if ($urandom_range(0, 39) == 0) burst = !burst;
         ins.opcode   = ($urandom_range(0, 3) != 0) ? group_ops[$urandom_range(0, 16)]
                                                     : ByteW'($urandom_range(0, 255));
         ins.acc      = ByteW'($urandom_range(0, 255));
         ins.zero     = 1'($urandom_range(0, 1));
         ins.sub      = 1'($urandom_range(0, 1));
         ins.half     = 1'($urandom_range(0, 1));
         ins.carry    = 1'($urandom_range(0, 1));
         ins.pc       = AddrW'($urandom_range(0, 65535));
         ins.hl       = AddrW'($urandom_range(0, 65535));
         ins.imm_low  = ByteW'($urandom_range(0, 255));
         ins.imm_high = ByteW'($urandom_range(0, 255));
         ins.ime      = 1'($urandom_range(0, 1));
         gap = burst ? 0 : $urandom_range(0, MAX_GAP);
         send_request(ins, execute_instr(ins), gap);
         random_sent++;
      end

      // Drop valid, drain the pipeline, then give stray responses a chance to show.
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d directed and %0d random requests (%0d in the group, %0d outside it),",
               directed_sent, random_sent, group_requests, outside_requests);
      $display("checked %0d responses under random stalls and one %0d-cycle hold-off.",
               responses_seen, HOLD_CYCLES);
      if (error_count == 0) begin
         $display("** misc_alu_and_branch_execute_unit: PASSED **");
      end else begin
         $display("** misc_alu_and_branch_execute_unit: FAILED **");
      end
      $finish;
   end

   // Response side: stall at random, once hold off long enough to back up the
   // unit, and compare every accepted response with the oldest outcome owed.
   initial begin : response_check
      outcome_t got;
      outcome_t want;
      int       stall;
      bit       burst;
      bit       bad;
      rsp_bus.ready = 1'b0;
      burst = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 39) == 0) burst = !burst;
         stall = burst ? 0 : $urandom_range(0, MAX_GAP);
         if (responses_seen == HOLD_AT && !hold_done) begin
            stall = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (stall > 0) begin
            rsp_bus.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);

         got.acc     = rsp_bus.acc_out;
         got.zero    = rsp_bus.zero_out;
         got.sub     = rsp_bus.sub_out;
         got.half    = rsp_bus.half_out;
         got.carry   = rsp_bus.carry_out;
         got.pc      = rsp_bus.pc_out;
         got.ime     = rsp_bus.ime_out;
         got.cycles  = rsp_bus.machine_cycles;
         got.handled = rsp_bus.handled;
         responses_seen++;

         if (pending_outcomes.size() == 0) begin
            if (error_count < REPORT_LIMIT)
               $display("%t: response with no request outstanding: %p", $realtime, got);
            error_count++;
         end else begin
            want = pending_outcomes.pop_front();
            bad = (got.acc !== want.acc) || (got.zero !== want.zero) ||
                  (got.sub !== want.sub) || (got.half !== want.half) ||
                  (got.carry !== want.carry) || (got.pc !== want.pc) ||
                  (got.ime !== want.ime) || (got.cycles !== want.cycles) ||
                  (got.handled !== want.handled);
            if (bad) begin
               if (error_count < REPORT_LIMIT) begin
                  $display("%t: response %0d mismatch", $realtime, responses_seen);
                  $display("   expected acc=%h znhc=%b%b%b%b pc=%h ime=%b cyc=%0d handled=%b",
                           want.acc, want.zero, want.sub, want.half, want.carry, want.pc,
                           want.ime, want.cycles, want.handled);
                  $display("   actual   acc=%h znhc=%b%b%b%b pc=%h ime=%b cyc=%0d handled=%b",
                           got.acc, got.zero, got.sub, got.half, got.carry, got.pc,
                           got.ime, got.cycles, got.handled);
               end
               error_count++;
            end
         end
      end
   end

endmodule

// ===== sim.f =====
rtl/mabe_pkg.sv
rtl/mabe_if.sv
rtl/mabe_decode.sv
rtl/mabe_alu.sv
rtl/mabe_branch.sv
rtl/misc_alu_and_branch_execute_unit.sv
dv/testbench.sv
